[hdl/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is held
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds while reset is asserted
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/oli_pkg.sv]
// shared constants, types and helper functions for the ordered list block
// no dependencies; imported by every module of the block
package oli_pkg;

    localparam int DEPTH  = 256;
    localparam int DATA_W = 32;
    localparam int CMD_W  = 3;
    localparam int POS_W  = 9;
    localparam int ST_W   = 2;
    localparam int LIST_W = 9;
    localparam int LEN_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (LEN_W > POS_W) ? LEN_W : POS_W;

    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

    // read-back or tree
    localparam int FAN_LOG = 4;
    localparam int FAN     = 1 << FAN_LOG;

    function automatic int tree_levels(input int depth);
        int lv;
        int span;
        lv   = 1;
        span = FAN;
        while (span < depth) begin
            lv   = lv + 1;
            span = span * FAN;
        end
        return lv;
    endfunction

    localparam int TREE_LEVELS = tree_levels(DEPTH);
    localparam int TREE_LEAVES = 1 << (FAN_LOG * TREE_LEVELS);
    localparam int CNT_W       = $clog2(TREE_LEVELS + 1);

    // offset of the first node of a tree level in the flat node array
    function automatic int node_off(input int lvl);
        int acc;
        acc = 0;
        for (int k = 1; k < lvl; k++) begin
            acc = acc + (TREE_LEAVES >> (FAN_LOG * k));
        end
        return acc;
    endfunction

    localparam int NODE_CNT = node_off(TREE_LEVELS + 1);

    // command broadcast to every cell
    typedef struct packed {
        logic              ins;
        logic              del;
        logic              app;
        logic [CMP_W-1:0]  pos;
        logic [CMP_W-1:0]  len;
        logic [DATA_W-1:0] value;
        logic [CMP_W-1:0]  rd_pos;
    } cell_ctrl_t;

endpackage

[hdl/oli_cell.sv]
// one storage cell of the list chain
// depends on oli_pkg
module oli_cell (
    input  logic                       clk,
    input  oli_pkg::cell_ctrl_t        ctrl,
    input  logic [oli_pkg::CMP_W-1:0]  idx,
    input  logic [oli_pkg::DATA_W-1:0] left_entry,
    input  logic [oli_pkg::DATA_W-1:0] right_entry,
    output logic [oli_pkg::DATA_W-1:0] entry,
    output logic [oli_pkg::DATA_W-1:0] read_tap
);
    import oli_pkg::*;

    logic [DATA_W-1:0] entry_reg;
    logic [DATA_W-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins)
        begin
            if (idx == ctrl.pos)
            begin
                entry_next = ctrl.value;
            end
            else if (idx > ctrl.pos)
            begin
                entry_next = left_entry;
            end
        end
        else if (ctrl.del)
        begin
            if (idx >= ctrl.pos)
            begin
                entry_next = right_entry;
            end
        end
        else if (ctrl.app)
        begin
            if (idx == ctrl.len)
            begin
                entry_next = ctrl.value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry    = entry_reg;
    assign read_tap = (idx == ctrl.rd_pos) ? entry_reg : '0;

endmodule

[hdl/oli_read_tree.sv]
// registered or tree that gathers the selected cell tap into one word
// depends on oli_pkg
module oli_read_tree (
    input  logic                       clk,
    input  logic [oli_pkg::DATA_W-1:0] taps [oli_pkg::DEPTH],
    output logic [oli_pkg::DATA_W-1:0] root
);
    import oli_pkg::*;

    logic [DATA_W-1:0] leaf_pad [TREE_LEAVES];
    logic [DATA_W-1:0] node_reg [NODE_CNT];

    for (genvar i = 0; i < TREE_LEAVES; i++)
    begin : g_leaf
        if (i < DEPTH)
        begin : g_used
            assign leaf_pad[i] = taps[i];
        end
        else
        begin : g_pad
            assign leaf_pad[i] = '0;
        end
    end

    for (genvar lv = 1; lv <= TREE_LEVELS; lv++)
    begin : g_level
        localparam int NODES    = TREE_LEAVES >> (FAN_LOG * lv);
        localparam int OFF      = node_off(lv);
        localparam int PREV_OFF = node_off(lv - 1);
        for (genvar n = 0; n < NODES; n++)
        begin : g_node
            logic [DATA_W-1:0] or_val;
            if (lv == 1)
            begin : g_from_leaf
                always_comb
                begin
                    or_val = '0;
                    for (int k = 0; k < FAN; k++)
                    begin
                        or_val = or_val | leaf_pad[n * FAN + k];
                    end
                end
            end
            else
            begin : g_from_node
                always_comb
                begin
                    or_val = '0;
                    for (int k = 0; k < FAN; k++)
                    begin
                        or_val = or_val | node_reg[PREV_OFF + n * FAN + k];
                    end
                end
            end
            always_ff @(posedge clk)
            begin
                node_reg[OFF + n] <= or_val;
            end
        end
    end

    assign root = node_reg[node_off(TREE_LEVELS)];

endmodule

[hdl/ordered_list_insert_delete.sv]
// insert, delete, append and clear results are registered at the accepting edge
// a read latches its position, then passes the cell taps through the registered or tree
// one transaction is in flight at a time; a new one is taken while the last result is taken
// reset (rst_n, async low) empties the list and drops any pending result; cells keep garbage
// depends on oli_pkg, oli_cell and oli_read_tree
module ordered_list_insert_delete (
    input  logic                        clk,
    input  logic                        rst_n,
    // command channel
    input  logic                        cmd_valid,
    output logic                        cmd_stall,
    input  logic [oli_pkg::CMD_W-1:0]   command,
    input  logic [oli_pkg::POS_W-1:0]   position,
    input  logic signed [oli_pkg::DATA_W-1:0] value,
    // response channel
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output logic signed [oli_pkg::DATA_W-1:0] read_value,
    output logic [oli_pkg::ST_W-1:0]    status,
    output logic [oli_pkg::LIST_W-1:0]  list_length
);
    import oli_pkg::*;

    // list length, the control state besides the read counter and the handshake
    logic [LEN_W-1:0]  length_reg;
    logic [LEN_W-1:0]  length_next;

    // read in flight through the or tree
    logic              busy_reg;
    logic              busy_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [CMP_W-1:0]  rd_pos_reg;
    logic              rd_ok_reg;
    logic [ST_W-1:0]   rd_status_reg;

    // response registers
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    logic [DATA_W-1:0] read_value_reg;
    logic [DATA_W-1:0] read_value_next;
    logic [ST_W-1:0]   status_reg;
    logic [ST_W-1:0]   status_next;
    logic [LIST_W-1:0] list_length_reg;
    logic [LIST_W-1:0] list_length_next;

    // command decode
    logic              accept;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  len_ext;
    logic              full;
    logic [ST_W-1:0]   dec_status;
    logic              do_ins;
    logic              do_del;
    logic              do_app;
    logic              do_clr;
    logic              is_read;
    logic              read_done;

    cell_ctrl_t        ctrl;
    logic [DATA_W-1:0] entry_q  [DEPTH];
    logic [DATA_W-1:0] tap_q    [DEPTH];
    logic [DATA_W-1:0] tree_root;

    // stall while a read is in the tree or the response register cannot drain
    assign cmd_stall = busy_reg || (rsp_valid_reg && rsp_stall);
    assign accept    = cmd_valid && !cmd_stall;

    assign pos_ext = CMP_W'(position);
    assign len_ext = CMP_W'(length_reg);
    assign full    = (length_reg == LEN_W'(DEPTH));

    // full check comes before the position check on insert
    always_comb
    begin
        dec_status = ST_OK;
        do_ins     = 1'b0;
        do_del     = 1'b0;
        do_app     = 1'b0;
        do_clr     = 1'b0;
        is_read    = 1'b0;
        case (command)
            CMD_INSERT:
            begin
                if (full)
                    dec_status = ST_FULL;
                else if (pos_ext > len_ext)
                    dec_status = ST_RANGE;
                else
                    do_ins = 1'b1;
            end
            CMD_DELETE:
            begin
                if (pos_ext >= len_ext)
                    dec_status = ST_RANGE;
                else
                    do_del = 1'b1;
            end
            CMD_APPEND:
            begin
                if (full)
                    dec_status = ST_FULL;
                else
                    do_app = 1'b1;
            end
            CMD_READ:
            begin
                is_read = 1'b1;
                if (pos_ext >= len_ext)
                    dec_status = ST_RANGE;
            end
            CMD_CLEAR:
            begin
                do_clr = 1'b1;
            end
            default:
            begin
                // unused codes do nothing and report ok
            end
        endcase
    end

    always_comb
    begin
        length_next = length_reg;
        if (accept)
        begin
            if (do_ins || do_app)
                length_next = length_reg + LEN_W'(1);
            else if (do_del)
                length_next = length_reg - LEN_W'(1);
            else if (do_clr)
                length_next = '0;
        end
    end

    // broadcast to the cell chain; read position comes from the latched copy
    always_comb
    begin
        ctrl.ins    = accept && do_ins;
        ctrl.del    = accept && do_del;
        ctrl.app    = accept && do_app;
        ctrl.pos    = pos_ext;
        ctrl.len    = len_ext;
        ctrl.value  = value;
        ctrl.rd_pos = rd_pos_reg;
    end

    // cell chain: inner cells see both neighbors; the ends see zero (left) or self (right)
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_W-1:0] left_d;
        logic [DATA_W-1:0] right_d;
        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_inner_l
            assign left_d = entry_q[i - 1];
        end
        if (i == DEPTH - 1)
        begin : g_last
            assign right_d = entry_q[i];
        end
        else
        begin : g_inner_r
            assign right_d = entry_q[i + 1];
        end

        oli_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .idx         (CMP_W'(i)),
            .left_entry  (left_d),
            .right_entry (right_d),
            .entry       (entry_q[i]),
            .read_tap    (tap_q[i])
        );
    end

    oli_read_tree u_tree (
        .clk  (clk),
        .taps (tap_q),
        .root (tree_root)
    );

    // the tree root is settled once the count has run down
    assign read_done = busy_reg && (cnt_reg == '0);

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (accept && is_read)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(TREE_LEVELS);
        end
        else if (read_done)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    // response register: loaded by a finished command or a finished read
    always_comb
    begin
        rsp_valid_next   = rsp_valid_reg;
        read_value_next  = read_value_reg;
        status_next      = status_reg;
        list_length_next = list_length_reg;
        if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;
        if (accept && !is_read)
        begin
            rsp_valid_next   = 1'b1;
            read_value_next  = '0;
            status_next      = dec_status;
            list_length_next = LIST_W'(length_next);
        end
        else if (read_done)
        begin
            rsp_valid_next   = 1'b1;
            read_value_next  = rd_ok_reg ? tree_root : '0;
            status_next      = rd_status_reg;
            list_length_next = LIST_W'(length_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg    <= '0;
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            length_reg    <= length_next;
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept && is_read)
        begin
            rd_pos_reg    <= pos_ext;
            rd_ok_reg     <= (dec_status == ST_OK);
            rd_status_reg <= dec_status;
        end
        read_value_reg  <= read_value_next;
        status_reg      <= status_next;
        list_length_reg <= list_length_next;
    end

    assign rsp_valid   = rsp_valid_reg;
    assign read_value  = read_value_reg;
    assign status      = status_reg;
    assign list_length = list_length_reg;

endmodule

[hdl/oli_checker.sv]
// port-level checks on the response side of the ordered list block
// depends on oli_pkg and assert_macros.svh; bound to the top level
`include "assert_macros.svh"

module oli_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        rsp_valid,
    input logic                        rsp_stall,
    input logic [oli_pkg::DATA_W-1:0]  read_value,
    input logic [oli_pkg::ST_W-1:0]    status,
    input logic [oli_pkg::LIST_W-1:0]  list_length
);
    import oli_pkg::*;

    // a stalled response keeps its payload
    `ASSERT_CLK(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall |=> rsp_valid && $stable(read_value) && $stable(status) && $stable(list_length), "response changed while stalled")

    // only defined status codes leave the block
    `ASSERT_CLK(a_status_code, clk, rst_n, rsp_valid |-> (status == ST_OK || status == ST_FULL || status == ST_RANGE), "undefined status code")

    // a nonzero read value only comes with an ok status
    `ASSERT_CLK(a_value_ok, clk, rst_n, rsp_valid && read_value != '0 |-> status == ST_OK, "read value with error status")

    // reported length never exceeds the list capacity
    `ASSERT_CLK(a_len_cap, clk, rst_n, rsp_valid |-> int'(list_length) <= DEPTH, "list length past capacity")

    // no response while reset is held
    `ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |-> !rsp_valid, "response during reset")

endmodule

bind ordered_list_insert_delete oli_checker u_oli_checker (.*);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// self-checking testbench for ordered_list_insert_delete: directed, fill-to-full, random and backpressure runs
// a built-in list predictor checks every response; depends on oli_pkg and the block's RTL

module testbench;
    import oli_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SHOW_LIMIT  = 10;
    localparam int IDLE_PCT    = 34;
    localparam int DRAIN_WAIT  = 12;
    localparam int DRAIN_LIMIT = 5000;
    localparam int HOLD_CYCLES = 200;

    // command codes the block ignores
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    typedef struct packed {
        logic signed [DATA_W-1:0] word;
        logic [ST_W-1:0]          st;
        logic [LIST_W-1:0]        len;
    } list_result_t;

    logic                     clk;
    logic                     rst_n       = 1'b1;
    logic                     cmd_valid   = 1'b0;
    logic [CMD_W-1:0]         command     = '0;
    logic [POS_W-1:0]         position    = '0;
    logic signed [DATA_W-1:0] value       = '0;
    logic                     rsp_stall   = 1'b0;
    logic                     cmd_stall;
    logic                     rsp_valid;
    logic signed [DATA_W-1:0] read_value;
    logic [ST_W-1:0]          status;
    logic [LIST_W-1:0]        list_length;

    // predicted list contents and length
    logic signed [DATA_W-1:0] list_words [DEPTH];
    int                       list_len = 0;
    int                       longest_len = 0;

    list_result_t             pending_results [$];

    int send_idle_pct = IDLE_PCT;
    int recv_idle_pct = IDLE_PCT;
    int hold_req      = 0;
    int hold_left     = 0;
    int cycle_count   = 0;
    int mismatch_count = 0;
    int results_checked = 0;
    int full_seen     = 0;
    int range_seen    = 0;
    int cmd_seen [8];

    ordered_list_insert_delete dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .command     (command),
        .position    (position),
        .value       (value),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .read_value  (read_value),
        .status      (status),
        .list_length (list_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     pending_results.size());
            $display("ordered_list_insert_delete test failed");
            $finish;
        end
    end

    // applies one command to the predicted list, returns the response it should give
    function automatic list_result_t apply_list_cmd(input logic [CMD_W-1:0] cmd,
                                                    input logic [POS_W-1:0] pos,
                                                    input logic signed [DATA_W-1:0] val);
        list_result_t r;
        int p;
        p      = int'(pos);
        r.word = '0;
        r.st   = ST_OK;
        case (cmd)
            CMD_INSERT:
                if (list_len >= DEPTH)
                    r.st = ST_FULL;
                else if (p > list_len)
                    r.st = ST_RANGE;
                else
                begin
                    for (int i = list_len; i > p; i--)
                        list_words[i] = list_words[i-1];
                    list_words[p] = val;
                    list_len++;
                end
            CMD_DELETE:
                if (p >= list_len)
                    r.st = ST_RANGE;
                else
                begin
                    for (int i = p; i + 1 < list_len; i++)
                        list_words[i] = list_words[i+1];
                    list_len--;
                end
            CMD_APPEND:
                if (list_len >= DEPTH)
                    r.st = ST_FULL;
                else
                begin
                    list_words[list_len] = val;
                    list_len++;
                end
            CMD_READ:
                if (p >= list_len)
                    r.st = ST_RANGE;
                else
                    r.word = list_words[p];
            CMD_CLEAR:
                list_len = 0;
            default:
                ;
        endcase
        if (list_len > longest_len)
            longest_len = list_len;
        r.len = LIST_W'(list_len);
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [DATA_W-1:0] exp_v,
                                   input logic [DATA_W-1:0] act_v);
        mismatch_count++;
        if (mismatch_count <= SHOW_LIMIT)
            $display("%0t: %s mismatch, expected %0h got %0h", $realtime, field, exp_v, act_v);
    endtask

    // predicts on every accepted command, compares every accepted response
    always @(posedge clk)
    begin : watch_channels
        list_result_t exp_r;
        list_result_t exp_in;
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
            begin
                exp_in = apply_list_cmd(command, position, value);
                pending_results.insert(pending_results.size(), exp_in);
                cmd_seen[command]++;
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= SHOW_LIMIT)
                        $display("%0t: response with no transaction pending", $realtime);
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    results_checked++;
                    if (exp_r.st == ST_FULL)
                        full_seen++;
                    if (exp_r.st == ST_RANGE)
                        range_seen++;
                    if (read_value !== exp_r.word)
                        report_mismatch("read_value", exp_r.word, read_value);
                    if (status !== exp_r.st)
                        report_mismatch("status", DATA_W'(exp_r.st), DATA_W'(status));
                    if (list_length !== exp_r.len)
                        report_mismatch("list_length", DATA_W'(exp_r.len), DATA_W'(list_length));
                end
            end
        end
    end

    // response side: random stalls, or a long counted hold-off on request
    always @(negedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left--;
        end
        else
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // offers one transaction and returns at the falling edge after it is taken
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                            input logic signed [DATA_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid = 1'b0;
            @(negedge clk);
        end
        cmd_valid = 1'b1;
        command   = cmd;
        position  = pos;
        value     = val;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // in-range position for the command most of the time, any 9-bit value otherwise
    function automatic logic [POS_W-1:0] pick_position(input logic [CMD_W-1:0] cmd,
                                                       input int in_range_pct);
        if ($urandom_range(99) >= in_range_pct)
            return POS_W'($urandom());
        if (cmd == CMD_INSERT)
            return POS_W'($urandom_range(list_len, 0));
        if (list_len == 0)
            return '0;
        return POS_W'($urandom_range(list_len - 1, 0));
    endfunction

    task automatic test_directed;
        send_cmd(CMD_READ,   9'd0,   32'sd5);
        send_cmd(CMD_DELETE, 9'd0,   32'sd7);
        send_cmd(CMD_INSERT, 9'd1,   32'sd9);
        send_cmd(CMD_INSERT, 9'd0,   32'sh7fffffff);
        send_cmd(CMD_INSERT, 9'd0,   32'sh80000000);
        send_cmd(CMD_APPEND, 9'h1ff, 32'shffffffff);
        send_cmd(CMD_APPEND, 9'd0,   32'sd0);
        send_cmd(CMD_INSERT, 9'd2,   32'sh55555555);   // middle
        send_cmd(CMD_INSERT, 9'd5,   32'shaaaaaaaa);   // position equal to length
        for (int i = 0; i < 6; i++)
            send_cmd(CMD_READ, POS_W'(i), 32'shffffffff);
        send_cmd(CMD_READ,   9'd6,   32'sd0);           // one past the end
        send_cmd(CMD_READ,   9'h1ff, 32'sd0);
        send_cmd(CMD_DELETE, 9'h1ff, 32'sd0);
        send_cmd(CMD_DELETE, 9'd2,   32'sd0);
        send_cmd(CMD_DELETE, 9'd0,   32'sd0);
        send_cmd(CMD_DELETE, 9'd3,   32'sd0);           // last entry
        for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++)
            send_cmd(CMD_W'(c), POS_W'($urandom()), $urandom());
        send_cmd(CMD_CLEAR,  9'h1ff, 32'shffffffff);
        send_cmd(CMD_READ,   9'd0,   32'sd0);
    endtask

    // grows the list to DEPTH, hits the full cases, then shrinks it again
    task automatic test_fill_to_full;
        logic [CMD_W-1:0] cmd;
        send_cmd(CMD_CLEAR, '0, '0);
        while (list_len < DEPTH)
        begin
            cmd = ($urandom_range(99) < 70) ? CMD_APPEND : CMD_INSERT;
            send_cmd(cmd, pick_position(cmd, 100), $urandom());
        end
        send_cmd(CMD_APPEND, '0,     $urandom());
        send_cmd(CMD_INSERT, 9'd0,   $urandom());
        send_cmd(CMD_INSERT, 9'h12c, $urandom());      // full is reported before range
        send_cmd(CMD_READ,   9'd255, '0);
        send_cmd(CMD_READ,   9'd256, '0);
        send_cmd(CMD_DELETE, 9'd256, '0);
        send_cmd(CMD_DELETE, 9'd255, '0);
        send_cmd(CMD_INSERT, 9'd255, $urandom());      // back to full at the end
        send_cmd(CMD_DELETE, 9'd0,   '0);
        for (int k = 0; k < 60; k++)
        begin
            cmd = ($urandom_range(1) != 0) ? CMD_DELETE : CMD_READ;
            send_cmd(cmd, pick_position(cmd, 95), $urandom());
        end
        send_cmd(CMD_CLEAR, '0, '0);
    endtask

    // mostly well-formed commands with random content, some out-of-range and spare codes
    task automatic test_random_mix(input int n_items);
        logic [CMD_W-1:0] cmd;
        int roll;
        for (int k = 0; k < n_items; k++)
        begin
            roll = $urandom_range(99);
            if (roll < 25)
                cmd = CMD_INSERT;
            else if (roll < 45)
                cmd = CMD_DELETE;
            else if (roll < 65)
                cmd = CMD_APPEND;
            else if (roll < 94)
                cmd = CMD_READ;
            else if (roll < 97)
                cmd = CMD_CLEAR;
            else
                cmd = CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
            send_cmd(cmd, pick_position(cmd, 85), $urandom());
        end
    endtask

    // response side holds off while commands keep coming, so the block backs up
    task automatic test_backpressure;
        logic [CMD_W-1:0] cmd;
        send_idle_pct = 0;
        hold_req      = HOLD_CYCLES;
        for (int k = 0; k < 16; k++)
        begin
            cmd = ($urandom_range(1) != 0) ? CMD_APPEND : CMD_READ;
            send_cmd(cmd, pick_position(cmd, 100), $urandom());
        end
        send_idle_pct = IDLE_PCT;
    endtask

    task automatic finish_run;
        int waited;
        int total;
        cmd_valid = 1'b0;
        waited    = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_WAIT) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            mismatch_count++;
            $display("%0d responses never arrived", pending_results.size());
        end
        total = 0;
        foreach (cmd_seen[c])
            total += cmd_seen[c];
        $display("ran %0d transactions, %0d responses checked: insert %0d, delete %0d,",
                 total, results_checked, cmd_seen[CMD_INSERT], cmd_seen[CMD_DELETE]);
        $display("  append %0d, read %0d, clear %0d, spare codes %0d;",
                 cmd_seen[CMD_APPEND], cmd_seen[CMD_READ], cmd_seen[CMD_CLEAR],
                 total - cmd_seen[CMD_INSERT] - cmd_seen[CMD_DELETE] - cmd_seen[CMD_APPEND]
                 - cmd_seen[CMD_READ] - cmd_seen[CMD_CLEAR]);
        $display("  list full %0d, out of range %0d, longest list %0d, errors %0d",
                 full_seen, range_seen, longest_len, mismatch_count);
        if (mismatch_count == 0)
            $display("ordered_list_insert_delete test passed");
        else
            $display("ordered_list_insert_delete test failed");
        $finish;
    endtask

    initial
    begin
        foreach (cmd_seen[c])
            cmd_seen[c] = 0;
        // a real falling edge so the asynchronous reset takes effect
        #1 rst_n = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_fill_to_full();
        test_random_mix(350);

        // long stretch with no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mix(250);
        send_idle_pct = IDLE_PCT;
        recv_idle_pct = IDLE_PCT;

        test_backpressure();
        test_random_mix(100);
        finish_run();
    end

endmodule

[sim.f]
+incdir+hdl
hdl/oli_pkg.sv
hdl/oli_cell.sv
hdl/oli_read_tree.sv
hdl/ordered_list_insert_delete.sv
hdl/oli_checker.sv
tb/sv/testbench.sv
